@@ rtl/s48c_pkg.sv @@
// shared types, constants and crc helpers for the 48-bit sensor frame codec
`default_nettype none

package s48c_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 96;

    // frame geometry
    localparam int FRAME_W   = 48;
    localparam int ADDR_W    = 10;
    localparam int WDATA_W   = 16;
    localparam int SAMPLE_W  = 21;
    localparam int RAW_W     = 20;
    localparam int REGVAL_W  = 16;
    localparam int CRC_W     = 8;

    // frame bit positions
    localparam int BIT_ADDR_LO = 38;
    localparam int BIT_WRITE   = 37;
    localparam int BIT_GEN_ERR = 36;
    localparam int BIT_FIXED   = 35;
    localparam int BIT_CMD_ERR = 35;
    localparam int BIT_SAT     = 34;
    localparam int BIT_INIT_LO = 33;
    localparam int BIT_DATA_LO = 8;

    // crc-8 settings
    localparam logic [CRC_W-1:0] CRC_POLY = 8'h2F;
    localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;

    // operation selector carried on tuser
    typedef enum logic {
        FUNC_BUILD = 1'b0,
        FUNC_CHECK = 1'b1
    } t_func;

    // decoded response fields
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [REGVAL_W-1:0]        register_value;
        logic                       frame_good;
        logic                       frame_saturated;
    } t_check_res;

    typedef logic [FRAME_W-1:0][CRC_W-1:0] t_crc_cols;

    // bit-serial crc, msb first over the whole frame; elaboration use only
    function automatic logic [CRC_W-1:0] crc_serial(logic [CRC_W-1:0] init,
                                                    logic [FRAME_W-1:0] d);
        logic [CRC_W-1:0] c;
        c = init;
        for (int i = FRAME_W - 1; i >= 0; i--) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY ^ {{(CRC_W-1){1'b0}}, d[i]};
            end else begin
                c = {c[CRC_W-2:0], d[i]};
            end
        end
        return c;
    endfunction

    // contribution of each frame bit to the crc (the crc is linear)
    function automatic t_crc_cols crc_columns();
        t_crc_cols cols;
        for (int i = 0; i < FRAME_W; i++) begin
            cols[i] = crc_serial({CRC_W{1'b0}}, FRAME_W'(1) << i);
        end
        return cols;
    endfunction

    localparam t_crc_cols        CRC_COLS      = crc_columns();
    localparam logic [CRC_W-1:0] CRC_INIT_TERM = crc_serial(CRC_INIT, {FRAME_W{1'b0}});

    // crc over bits 8..47, low byte taken as zero: one xor tree
    function automatic logic [CRC_W-1:0] frame_crc(logic [FRAME_W-1:0] f);
        logic [CRC_W-1:0] c;
        c = CRC_INIT_TERM;
        for (int i = BIT_DATA_LO; i < FRAME_W; i++) begin
            if (f[i]) begin
                c = c ^ CRC_COLS[i];
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/s48c_build.sv @@
// request frame assembly with crc in the low byte
`default_nettype none

module s48c_build
    import s48c_pkg::*;
(
    input  wire logic [ADDR_W-1:0]  i_reg_address,
    input  wire logic               i_is_write,
    input  wire logic [WDATA_W-1:0] i_write_data,
    output logic [FRAME_W-1:0]      o_request_frame
);

    logic [FRAME_W-1:0] w_body;

    // address, write flag, fixed bit and write data
    always_comb begin
        w_body = {FRAME_W{1'b0}};
        w_body[FRAME_W-1:BIT_ADDR_LO] = i_reg_address;
        w_body[BIT_FIXED] = 1'b1;
        if (i_is_write) begin
            w_body[BIT_WRITE] = 1'b1;
            w_body[BIT_DATA_LO +: WDATA_W] = i_write_data;
        end
    end

    // append crc
    assign o_request_frame = {w_body[FRAME_W-1:CRC_W], frame_crc(w_body)};

endmodule

`default_nettype wire

@@ rtl/s48c_check.sv @@
// response frame validation and datum decode
`default_nettype none

module s48c_check
    import s48c_pkg::*;
(
    input  wire logic [FRAME_W-1:0] i_response_frame,
    input  wire logic               i_negate_value,
    input  wire logic               i_temp_mode,
    output t_check_res              o_res
);

    logic [RAW_W-1:0]           w_raw;
    logic signed [SAMPLE_W-1:0] w_ext;
    logic signed [SAMPLE_W-1:0] w_neg;
    logic                       w_err;
    logic                       w_init;
    logic                       w_crc_ok;

    // error flags, init state and crc compare
    assign w_err    = i_response_frame[BIT_GEN_ERR] | i_response_frame[BIT_CMD_ERR];
    assign w_init   = i_response_frame[BIT_INIT_LO] & i_response_frame[BIT_INIT_LO+1];
    assign w_crc_ok = (i_response_frame[CRC_W-1:0] == frame_crc(i_response_frame));

    // sign extend, optional negate, optional floor shift by 4
    assign w_raw = i_response_frame[BIT_DATA_LO +: RAW_W];
    assign w_ext = $signed({w_raw[RAW_W-1], w_raw});
    assign w_neg = i_negate_value ? -w_ext : w_ext;

    always_comb begin
        o_res.sample_value    = i_temp_mode ? (w_neg >>> 4) : w_neg;
        o_res.register_value  = i_response_frame[BIT_DATA_LO +: REGVAL_W];
        o_res.frame_good      = ~w_err & ~w_init & w_crc_ok;
        o_res.frame_saturated = i_response_frame[BIT_SAT];
    end

endmodule

`default_nettype wire

@@ rtl/spi48_sensor_frame_codec_top.sv @@
// a request is taken into the input register when accepted and moves on to the result
// register when that register is free (empty or being taken)
// throughput: one request per cycle while the output is not stalled; the output register is free again when taken
// the crc is one xor tree between the input register and the result register
// reset (i_rst_n low, synchronous) empties both stages and sets the burst
// state to good and not saturated
`default_nettype none

module spi48_sensor_frame_codec_top
    import s48c_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: reg_address[9:0], is_write[10], write_data[26:11],
    //        response_frame[74:27], negate_value[75], temp_mode[76], zero[79:77]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: func[0]
    input  wire logic                   i_s_axis_tuser,
    // tlast: last_in_burst
    input  wire logic                   i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // tdata: request_frame[47:0], sample_value[68:48], register_value[84:69],
    //        frame_good[85], frame_saturated[86], burst_good[87],
    //        burst_saturated[88], zero[95:89]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tlast: burst_done
    output logic                        o_m_axis_tlast
);

    // input stage
    logic               r_s1_valid;
    t_func              r_s1_func;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_wr;
    logic [WDATA_W-1:0] r_s1_wdata;
    logic [FRAME_W-1:0] r_s1_resp;
    logic               r_s1_neg;
    logic               r_s1_temp;
    logic               r_s1_last;

    // result stage
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;
    logic [OUT_TDATA_W-1:0] n_out_data;
    logic                   n_out_last;

    // burst accumulators
    logic r_burst_good;
    logic r_burst_sat;
    logic n_burst_good;
    logic n_burst_sat;

    logic               w_out_free;
    logic               w_s1_adv;
    logic               w_in_acc;
    logic               w_bg;
    logic               w_bs;
    logic [FRAME_W-1:0] w_request;
    t_check_res         w_chk;

    // handshake
    assign w_out_free      = ~r_out_valid | i_m_axis_tready;
    assign w_s1_adv        = r_s1_valid & w_out_free;
    assign o_s_axis_tready = ~r_s1_valid | w_out_free;
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_func  <= t_func'(i_s_axis_tuser);
            r_s1_addr  <= i_s_axis_tdata[9:0];
            r_s1_wr    <= i_s_axis_tdata[10];
            r_s1_wdata <= i_s_axis_tdata[26:11];
            r_s1_resp  <= i_s_axis_tdata[74:27];
            r_s1_neg   <= i_s_axis_tdata[75];
            r_s1_temp  <= i_s_axis_tdata[76];
            r_s1_last  <= i_s_axis_tlast;
        end
    end

    s48c_build u_build (
        .i_reg_address   (r_s1_addr),
        .i_is_write      (r_s1_wr),
        .i_write_data    (r_s1_wdata),
        .o_request_frame (w_request)
    );

    s48c_check u_check (
        .i_response_frame (r_s1_resp),
        .i_negate_value   (r_s1_neg),
        .i_temp_mode      (r_s1_temp),
        .o_res            (w_chk)
    );

    // result word and burst update
    assign w_bg = r_burst_good & w_chk.frame_good;
    assign w_bs = r_burst_sat | w_chk.frame_saturated;

    always_comb begin
        n_burst_good = r_burst_good;
        n_burst_sat  = r_burst_sat;
        n_out_data   = {OUT_TDATA_W{1'b0}};
        n_out_last   = 1'b0;
        case (r_s1_func)
            FUNC_BUILD: begin
                n_out_data[FRAME_W-1:0] = w_request;
            end
            FUNC_CHECK: begin
                n_out_data[88:48] = {w_bs, w_bg, w_chk.frame_saturated,
                                     w_chk.frame_good, w_chk.register_value,
                                     w_chk.sample_value};
                n_out_last = r_s1_last;
                if (r_s1_last) begin
                    n_burst_good = 1'b1;
                    n_burst_sat  = 1'b0;
                end else begin
                    n_burst_good = w_bg;
                    n_burst_sat  = w_bs;
                end
            end
            default: begin
                n_out_data = {OUT_TDATA_W{1'b0}};
            end
        endcase
    end

    // result register and burst state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_burst_good <= 1'b1;
            r_burst_sat  <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_s1_adv) begin
                r_burst_good <= n_burst_good;
                r_burst_sat  <= n_burst_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/s48c_checker.sv @@
// port-level checks for the frame codec, bound to the top level
`default_nettype none

module s48c_checker
    import s48c_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                   o_m_axis_tlast
);

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // an empty result stage never blocks a request
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("request blocked with empty result stage");

    // a request frame always carries the fixed bit and no decoded fields
    a_build_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[47:0] != 48'd0) |->
            o_m_axis_tdata[35] && (o_m_axis_tdata[88:48] == 41'd0) && !o_m_axis_tlast)
        else $error("malformed request result");

    // burst flags cover the frame flags
    a_burst_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (!o_m_axis_tdata[87] || o_m_axis_tdata[85]) &&
            (!o_m_axis_tdata[86] || o_m_axis_tdata[88]))
        else $error("burst flags disagree with frame flags");

endmodule

bind spi48_sensor_frame_codec_top s48c_checker u_s48c_checker (.*);

`default_nettype wire
